/* hw/rtl/mbc1rbw_pkg.sv */
// shared types and constants for the mbc1 rom bank write decoder
package mbc1rbw_pkg;

  localparam int unsigned AddrWidth  = 16;
  localparam int unsigned DataWidth  = 8;
  localparam int unsigned BankWidth  = 7;
  localparam int unsigned LowBits    = 5;
  localparam int unsigned UpperBits  = 2;
  localparam int unsigned RegionBits = 3;

  // address windows, picked by the top three address bits
  typedef enum logic [RegionBits-1:0] {
    RegionRamEnable = 3'b000,
    RegionRomBank   = 3'b001,
    RegionUpperBits = 3'b010,
    RegionMode      = 3'b011
  } region_e;

  localparam logic BankModeRom = 1'b0;

  typedef struct packed {
    logic                 filtered;
    logic                 switch_bank;
    logic [BankWidth-1:0] rom_bank;
  } result_t;

endpackage

/* hw/rtl/mbc1rbw_if.sv */
// valid/ready channels for cpu writes and decode results
interface mbc1rbw_req_if;
  import mbc1rbw_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [AddrWidth-1:0] write_address;
  logic [DataWidth-1:0] write_byte;

  modport source (output valid, write_address, write_byte, input ready);
  modport sink   (input valid, write_address, write_byte, output ready);
endinterface

interface mbc1rbw_rsp_if;
  import mbc1rbw_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 filtered;
  logic                 switch_bank;
  logic [BankWidth-1:0] rom_bank;

  modport source (output valid, filtered, switch_bank, rom_bank, input ready);
  modport sink   (input valid, filtered, switch_bank, rom_bank, output ready);
endinterface

/* hw/rtl/mbc1rbw_decode.sv */
// address decode, bank number forming and controller state
module mbc1rbw_decode (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              commit_i,
  input  logic [mbc1rbw_pkg::AddrWidth-1:0] write_address_i,
  input  logic [mbc1rbw_pkg::DataWidth-1:0] write_byte_i,
  output mbc1rbw_pkg::result_t              result_o
);
  import mbc1rbw_pkg::*;

  logic [UpperBits-1:0]  upper_q, upper_d;
  logic                  mode_q, mode_d;
  logic [LowBits-1:0]    low_bits;
  logic [UpperBits-1:0]  high_bits;
  logic [RegionBits-1:0] region;

  assign region    = write_address_i[AddrWidth-1 -: RegionBits];
  assign low_bits  = write_byte_i[LowBits-1:0];
  assign high_bits = (mode_q == BankModeRom) ? upper_q : '0;

  always_comb begin
    upper_d  = upper_q;
    mode_d   = mode_q;
    result_o = '0;
    case (region)
      RegionRamEnable: begin
        result_o.filtered = 1'b1;
      end
      RegionRomBank: begin
        result_o.filtered    = 1'b1;
        result_o.switch_bank = 1'b1;
        // bank with zero low bits maps to the next bank up
        result_o.rom_bank    = {high_bits,
                                (low_bits == '0) ? LowBits'(1) : low_bits};
      end
      RegionUpperBits: begin
        result_o.filtered = 1'b1;
        upper_d           = write_byte_i[UpperBits-1:0];
      end
      RegionMode: begin
        result_o.filtered = 1'b1;
        mode_d            = write_byte_i[0];
      end
      default: begin
        result_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= '0;
      mode_q  <= BankModeRom;
    end else if (commit_i) begin
      upper_q <= upper_d;
      mode_q  <= mode_d;
    end
  end

endmodule

/* hw/rtl/mbc1_rom_bank_write.sv */
// top level of the mbc1 rom bank write decoder
// Decodes cpu bus writes the way an mbc1 cartridge controller does: each
// write transaction yields exactly one result transaction telling whether
// the controller consumed the write and, for writes to 0x2000-0x3fff, the
// rom bank to switch to. Writes to 0x4000-0x5fff and 0x6000-0x7fff update
// the upper bank bits and the banking mode, which affect later bank writes.
// One transaction is accepted every cycle while ready is high; a write goes
// into the input register when it is accepted and moves on into the result
// register once that register is free, where its result is offered. While a
// finished result waits to be taken the input register still takes one more
// write, then ready drops until the result leaves.
module mbc1_rom_bank_write (
  input  logic  clk_i,
  input  logic  rst_ni,
  mbc1rbw_req_if.sink   req_i,
  mbc1rbw_rsp_if.source rsp_o
);
  import mbc1rbw_pkg::*;

  logic                 in_valid_q;
  logic [AddrWidth-1:0] in_addr_q;
  logic [DataWidth-1:0] in_byte_q;
  logic                 out_valid_q;
  result_t              out_result_q;
  result_t              result;
  logic                 out_free;
  logic                 advance;

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign advance     = in_valid_q && out_free;
  assign req_i.ready = !in_valid_q || advance;

  mbc1rbw_decode u_decode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .commit_i        (advance),
    .write_address_i (in_addr_q),
    .write_byte_i    (in_byte_q),
    .result_o        (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (out_free) begin
        out_valid_q <= advance;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_addr_q <= req_i.write_address;
      in_byte_q <= req_i.write_byte;
    end
    if (advance) begin
      out_result_q <= result;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.filtered    = out_result_q.filtered;
  assign rsp_o.switch_bank = out_result_q.switch_bank;
  assign rsp_o.rom_bank    = out_result_q.rom_bank;

endmodule
